// ===== rtl/core/sps_pkg.sv =====
// sps_pkg: beat types, register map, pin codes and reset values of the servo pulse sequencer.
// Depends on nothing; imported by every module under rtl/core.
`default_nettype none

package sps_pkg;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CONNECTED_MASK   = 2'd0,
        CFG_IDLE_RELOAD      = 2'd1,
        CFG_BASE_TICKS       = 2'd2,
        CFG_TICKS_PER_DEGREE = 2'd3
    } t_cfg_index;

    localparam logic [7:0]  RST_CONNECTED_MASK   = 8'd0;
    localparam logic [15:0] RST_IDLE_RELOAD      = 16'd60535;
    localparam logic [15:0] RST_BASE_TICKS       = 16'd1000;
    localparam logic [7:0]  RST_TICKS_PER_DEGREE = 8'd11;

    localparam logic [15:0] FULL_RELOAD  = 16'hFFFF;
    localparam logic [7:0]  MAX_ANGLE    = 8'd180;
    localparam int unsigned MASK_CHANNELS = 8;

    typedef enum logic {
        FUNC_TICK      = 1'b0,
        FUNC_SET_ANGLE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        PIN_HOLD  = 2'd0,
        PIN_RAISE = 2'd1,
        PIN_LOWER = 2'd2
    } t_pin_action;

    typedef struct packed {
        t_func       func;
        logic [2:0]  target_channel;
        logic [7:0]  new_angle;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  channel;
        t_pin_action pin_action;
        logic [15:0] next_reload;
    } t_out_beat;

    typedef struct packed {
        logic [7:0]  connected_mask;
        logic [15:0] idle_reload;
        logic [15:0] base_ticks;
        logic [7:0]  ticks_per_degree;
    } t_cfg;

    // What the slot state tells the reload calculation about the current slot.
    typedef struct packed {
        logic [2:0] channel;
        logic       connected;
        logic       high;
        logic [7:0] angle;
    } t_slot_info;

endpackage

`default_nettype wire

// ===== rtl/core/sps_cfg_regs.sv =====
// sps_cfg_regs: configuration register file of the servo pulse sequencer.
// Depends on sps_pkg (t_cfg, t_cfg_index, reset values).
`default_nettype none

module sps_cfg_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [sps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sps_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output sps_pkg::t_cfg                         o_cfg
);
    import sps_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_CONNECTED_MASK:   n_cfg.connected_mask   = i_cfg_data[7:0];
                CFG_IDLE_RELOAD:      n_cfg.idle_reload      = i_cfg_data;
                CFG_BASE_TICKS:       n_cfg.base_ticks       = i_cfg_data;
                CFG_TICKS_PER_DEGREE: n_cfg.ticks_per_degree = i_cfg_data[7:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.connected_mask   <= RST_CONNECTED_MASK;
            r_cfg.idle_reload      <= RST_IDLE_RELOAD;
            r_cfg.base_ticks       <= RST_BASE_TICKS;
            r_cfg.ticks_per_degree <= RST_TICKS_PER_DEGREE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/core/sps_slot_state.sv =====
// sps_slot_state: current slot, per-channel pin level and angle table.
// Depends on sps_pkg (t_slot_info, MAX_ANGLE, MASK_CHANNELS).
`default_nettype none

module sps_slot_state #(
    parameter int unsigned CHANNELS = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_tick,
    input  wire logic          i_set,
    input  wire logic [2:0]    i_target,
    input  wire logic [7:0]    i_angle,
    input  wire logic [7:0]    i_mask,
    output sps_pkg::t_slot_info o_info
);
    import sps_pkg::*;

    localparam int unsigned SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic [CHANNELS-1:0] r_high;
    logic [CHANNELS-1:0] n_high;
    logic [7:0] r_angle [CHANNELS];

    logic              connected;
    logic              set_ok;
    logic [SLOT_W-1:0] set_idx;
    logic [7:0]        sat_angle;

    assign connected = (32'(r_slot) < MASK_CHANNELS) && i_mask[3'(r_slot)];
    assign set_ok    = 32'(i_target) < CHANNELS;
    assign set_idx   = SLOT_W'(i_target);
    assign sat_angle = (i_angle > MAX_ANGLE) ? MAX_ANGLE : i_angle;

    always_comb begin
        n_slot = r_slot;
        n_high = r_high;
        if (i_tick) begin
            // Stay on a connected slot that is about to go high; advance otherwise.
            if (connected) begin
                n_high[r_slot] = !r_high[r_slot];
            end
            if (!connected || r_high[r_slot]) begin
                n_slot = (r_slot == SLOT_W'(CHANNELS - 1)) ? '0 : r_slot + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_high <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_angle[i] <= '0;
            end
        end else begin
            r_slot <= n_slot;
            r_high <= n_high;
            if (i_set && set_ok) begin
                r_angle[set_idx] <= sat_angle;
            end
        end
    end

    assign o_info.channel   = 3'(r_slot);
    assign o_info.connected = connected;
    assign o_info.high      = r_high[r_slot];
    assign o_info.angle     = r_angle[r_slot];

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_slot) < CHANNELS)
        else $error("slot index out of range");

    a_raise_holds_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick && connected && !r_high[r_slot] |=> r_slot == $past(r_slot) && r_high[r_slot])
        else $error("slot moved after raising its pin");

    a_lower_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tick && connected && r_high[r_slot] && CHANNELS > 1 |=> r_slot != $past(r_slot))
        else $error("slot did not advance after lowering its pin");

endmodule

`default_nettype wire

// ===== rtl/core/sps_reload_calc.sv =====
// sps_reload_calc: pulse length and timer reload for one tick.
// Depends on sps_pkg (t_slot_info, t_cfg, t_out_beat, pin codes).
`default_nettype none

module sps_reload_calc (
    input  wire sps_pkg::t_slot_info i_info,
    input  wire sps_pkg::t_cfg       i_cfg,
    output sps_pkg::t_out_beat       o_beat
);
    import sps_pkg::*;

    logic [15:0] product;
    logic [15:0] pulse;

    // Reloads wrap modulo 65536, so the pulse is only needed to 16 bits.
    assign product = 16'(i_cfg.ticks_per_degree) * 16'(i_info.angle);
    assign pulse   = i_cfg.base_ticks + product;

    always_comb begin
        o_beat.channel = i_info.channel;
        if (!i_info.connected) begin
            o_beat.pin_action  = PIN_HOLD;
            o_beat.next_reload = i_cfg.idle_reload;
        end else if (!i_info.high) begin
            o_beat.pin_action  = PIN_RAISE;
            o_beat.next_reload = FULL_RELOAD - pulse;
        end else begin
            o_beat.pin_action  = PIN_LOWER;
            o_beat.next_reload = i_cfg.idle_reload + pulse;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/servo_pulse_sequencer.sv =====
// servo_pulse_sequencer: top level, input register, result register and handshakes.
// Depends on sps_pkg, sps_cfg_regs, sps_slot_state and sps_reload_calc.
//
//   port group   dir  handshake              beat contents
//   in           in   i_in_valid/o_in_stall  t_in_beat: func, target_channel, new_angle
//   out          out  o_out_valid/i_out_stall t_out_beat: channel, pin_action, next_reload
//   cfg          in   i_cfg_we (no wait)     i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the output is not stalled. A beat lands in the input
// register; when it steps, the slot logic and one 8x8 multiply-add turn a tick into a result
// beat in the output register. A set-angle beat writes the angle table at that same step and
// yields no result.
// Reset (synchronous, i_rst_n low) clears both valids, the slot, pin levels, angles and
// loads the register defaults. A stalled output holds its beat; the input register
// keeps taking beats as long as a tick behind it can move on.
`default_nettype none

module servo_pulse_sequencer #(
    parameter int unsigned CHANNELS = 8
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire sps_pkg::t_in_beat                i_in_beat,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output sps_pkg::t_out_beat                    o_out_beat,
    input  wire logic                             i_cfg_we,
    input  wire logic [sps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [sps_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sps_pkg::*;

    t_cfg       cfg;
    t_slot_info info;
    t_out_beat  calc_beat;

    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_out_valid;
    t_out_beat r_out;

    logic out_free;
    logic is_tick;
    logic step;
    logic in_take;

    // The output register can take a beat when empty or being drained this cycle.
    assign out_free = !r_out_valid || !i_out_stall;
    assign is_tick  = r_in.func == FUNC_TICK;
    // Set-angle beats need no output slot; ticks wait for one.
    assign step     = r_in_valid && (!is_tick || out_free);
    assign in_take  = !r_in_valid || step;

    assign o_in_stall = !in_take;

    sps_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sps_slot_state #(
        .CHANNELS (CHANNELS)
    ) u_slot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (step && is_tick),
        .i_set    (step && !is_tick),
        .i_target (r_in.target_channel),
        .i_angle  (r_in.new_angle),
        .i_mask   (cfg.connected_mask),
        .o_info   (info)
    );

    sps_reload_calc u_calc (
        .i_info (info),
        .i_cfg  (cfg),
        .o_beat (calc_beat)
    );

    // Hold the input beat until it steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_in <= i_in_beat;
        end
    end

    // Load a result on a tick step; drop the valid once the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && is_tick) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && is_tick) begin
            r_out <= calc_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid && $stable(r_out))
        else $error("stalled result beat was lost or changed");

    a_tick_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && is_tick |-> out_free)
        else $error("tick stepped into a full output register");

    a_empty_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("empty input register stalled the input");

endmodule

`default_nettype wire
